### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the heap modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge while out of reset.
`define IMH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true while out of reset.
`define IMH_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// Types, widths and codes of the indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int NUM_IDS  = 1024;
    localparam int KEY_BITS = 32;
    localparam int ID_W     = 10;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(NUM_IDS + 1);
    localparam int SLOT_W   = $clog2(NUM_IDS);
    localparam int MODE_W   = 2;
    localparam int OUT_W    = 3;

    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [OUT_W-1:0] OUT_NONE    = 3'd0;
    localparam logic [OUT_W-1:0] OUT_INSERT  = 3'd1;
    localparam logic [OUT_W-1:0] OUT_REMOVE  = 3'd2;
    localparam logic [OUT_W-1:0] OUT_KEYCHG  = 3'd3;
    localparam logic [OUT_W-1:0] OUT_POPPED  = 3'd4;
    localparam logic [OUT_W-1:0] OUT_EMPTY   = 3'd5;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_CLR,
        DP_CAPTURE,
        DP_FETCH,
        DP_SLOTRD,
        DP_INSERT,
        DP_POP,
        DP_TAKE,
        DP_CLRPRES,
        DP_UPDATE,
        DP_UP_RD,
        DP_UP_MOVE,
        DP_DN_RD,
        DP_DN_MOVE,
        DP_FINAL,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic             ld_outc;
        logic [OUT_W-1:0] outc;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              elig;
        logic              id_valid;
        logic              pres;
        logic              size_zero;
        logic              size_one;
        logic              size_full;
        logic              pos_ok;
        logic              pos_is_last;
        logic              key_same;
        logic              key_less;
        logic              upd_same;
        logic              upd_less;
        logic              at_root;
        logic              up_swap;
        logic              no_child;
        logic              dn_swap;
        logic              clr_last;
    } t_sts;

endpackage

### design/imh_dp.sv
// ----------------------------------------------------------------------------
// imh_dp
// Heap datapath: slot memory, id position memory, sift registers, result regs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imh_dp
    import imh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [ID_W-1:0]   i_item_id,
    input  logic [KEY_W-1:0]  i_new_key,
    input  logic              i_eligible,
    output t_sts              o_sts,
    output logic [OUT_W-1:0]  o_outcome,
    output logic [ID_W-1:0]   o_out_id,
    output logic [KEY_W-1:0]  o_out_key,
    output logic [CNT_W-1:0]  o_entry_count
);

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [KEY_BITS-1:0] key;
    } t_slot;

    t_slot               r_slot_mem [NUM_IDS];
    logic [SLOT_W:0]     r_pos_mem  [NUM_IDS];

    t_slot               r_rd_a, r_rd_b;
    logic [SLOT_W:0]     r_pm;
    logic [MODE_W-1:0]   r_mode;
    logic [ID_W-1:0]     r_id;
    logic [KEY_BITS-1:0] r_key_in;
    logic                r_elig;
    logic [SLOT_W-1:0]   r_pos;
    logic [CNT_W-1:0]    r_size;
    t_slot               r_mv;
    logic [KEY_BITS-1:0] r_old_key;
    logic [OUT_W-1:0]    r_outc;
    logic [ID_W-1:0]     r_oid;
    logic [KEY_BITS-1:0] r_okey;
    logic [SLOT_W-1:0]   r_clr;
    logic [OUT_W-1:0]    r_o_outcome;
    logic [ID_W-1:0]     r_o_id;
    logic [KEY_W-1:0]    r_o_key;
    logic [CNT_W-1:0]    r_o_count;

    logic [CNT_W-1:0]    size_m1;
    logic [SLOT_W-1:0]   parent;
    logic [SLOT_W:0]     left;
    logic [SLOT_W+1:0]   right;
    logic                l_ok, r_ok, l_less, r_less;
    logic [KEY_BITS-1:0] best_key;
    t_slot               pick;
    logic [SLOT_W-1:0]   pick_idx;

    logic                re_a, re_b, re_p, we_s, we_p;
    logic [SLOT_W-1:0]   addr_a, addr_b, addr_s, addr_p;
    t_slot               wdata_s;
    logic [SLOT_W:0]     wdata_p;

    assign size_m1  = r_size - CNT_W'(1);
    assign parent   = SLOT_W'((r_pos - SLOT_W'(1)) >> 1);
    assign left     = {r_pos, 1'b1};
    assign right    = (SLOT_W+2)'(left) + (SLOT_W+2)'(1);
    assign l_ok     = (CNT_W+1)'(left) < (CNT_W+1)'(r_size);
    assign r_ok     = (CNT_W+1)'(right) < (CNT_W+1)'(r_size);
    assign l_less   = l_ok && (r_rd_a.key < r_mv.key);
    assign best_key = l_less ? r_rd_a.key : r_mv.key;
    assign r_less   = r_ok && (r_rd_b.key < best_key);
    assign pick     = r_less ? r_rd_b : r_rd_a;
    assign pick_idx = r_less ? right[SLOT_W-1:0] : left[SLOT_W-1:0];

    always_comb begin
        re_a    = 1'b0;
        re_b    = 1'b0;
        re_p    = 1'b0;
        we_s    = 1'b0;
        we_p    = 1'b0;
        addr_a  = '0;
        addr_b  = size_m1[SLOT_W-1:0];
        addr_s  = r_pos;
        addr_p  = r_id[SLOT_W-1:0];
        wdata_s = r_mv;
        wdata_p = {1'b1, r_pos};
        unique case (i_cmd.op)
            DP_CLR: begin
                we_p    = 1'b1;
                addr_p  = r_clr;
                wdata_p = '0;
            end
            DP_FETCH: begin
                re_a = 1'b1;
                re_b = 1'b1;
                re_p = 1'b1;
            end
            DP_SLOTRD: begin
                re_a   = 1'b1;
                addr_a = r_pm[SLOT_W-1:0];
            end
            DP_POP: begin
                we_p    = 1'b1;
                addr_p  = r_rd_a.id[SLOT_W-1:0];
                wdata_p = '0;
            end
            DP_TAKE, DP_CLRPRES: begin
                we_p    = 1'b1;
                wdata_p = '0;
            end
            DP_UP_RD: begin
                re_a   = 1'b1;
                addr_a = parent;
            end
            DP_UP_MOVE: begin
                we_s    = 1'b1;
                we_p    = 1'b1;
                wdata_s = r_rd_a;
                addr_p  = r_rd_a.id[SLOT_W-1:0];
            end
            DP_DN_RD: begin
                re_a   = 1'b1;
                re_b   = 1'b1;
                addr_a = left[SLOT_W-1:0];
                addr_b = right[SLOT_W-1:0];
            end
            DP_DN_MOVE: begin
                we_s    = 1'b1;
                we_p    = 1'b1;
                wdata_s = pick;
                addr_p  = pick.id[SLOT_W-1:0];
            end
            DP_FINAL: begin
                we_s   = 1'b1;
                we_p   = 1'b1;
                addr_p = r_mv.id[SLOT_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_s) begin
            r_slot_mem[addr_s] <= wdata_s;
        end
        if (re_a) begin
            r_rd_a <= r_slot_mem[addr_a];
        end
        if (re_b) begin
            r_rd_b <= r_slot_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_p) begin
            r_pos_mem[addr_p] <= wdata_p;
        end
        if (re_p) begin
            r_pm <= r_pos_mem[addr_p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
            r_clr  <= '0;
        end else begin
            unique case (i_cmd.op)
                DP_CLR:    r_clr  <= r_clr + SLOT_W'(1);
                DP_INSERT: r_size <= r_size + CNT_W'(1);
                DP_POP:    r_size <= size_m1;
                DP_TAKE:   r_size <= size_m1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_outc) begin
            r_outc <= i_cmd.outc;
        end
        unique case (i_cmd.op)
            DP_CAPTURE: begin
                r_mode   <= i_mode;
                r_id     <= i_item_id;
                r_key_in <= i_new_key[KEY_BITS-1:0];
                r_elig   <= i_eligible;
                r_oid    <= i_item_id;
                r_okey   <= '0;
            end
            DP_SLOTRD: r_pos <= r_pm[SLOT_W-1:0];
            DP_INSERT: begin
                r_pos <= r_size[SLOT_W-1:0];
                r_mv  <= '{id: r_id, key: r_key_in};
            end
            DP_POP: begin
                r_oid  <= r_rd_a.id;
                r_okey <= r_rd_a.key;
                r_mv   <= r_rd_b;
                r_pos  <= '0;
            end
            DP_TAKE: begin
                r_mv      <= r_rd_b;
                r_old_key <= r_rd_a.key;
            end
            DP_UPDATE:  r_mv  <= '{id: r_id, key: r_key_in};
            DP_UP_MOVE: r_pos <= parent;
            DP_DN_MOVE: r_pos <= pick_idx;
            DP_EMIT: begin
                r_o_outcome <= r_outc;
                r_o_id      <= r_oid;
                r_o_key     <= KEY_W'(r_okey);
                r_o_count   <= r_size;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.mode        = r_mode;
        o_sts.elig        = r_elig;
        o_sts.id_valid    = CNT_W'(r_id) < CNT_W'(NUM_IDS);
        o_sts.pres        = r_pm[SLOT_W];
        o_sts.size_zero   = r_size == '0;
        o_sts.size_one    = r_size == CNT_W'(1);
        o_sts.size_full   = r_size == CNT_W'(NUM_IDS);
        o_sts.pos_ok      = CNT_W'(r_pos) < r_size;
        o_sts.pos_is_last = CNT_W'(r_pos) == size_m1;
        o_sts.key_same    = r_mv.key == r_old_key;
        o_sts.key_less    = r_mv.key < r_old_key;
        o_sts.upd_same    = r_key_in == r_rd_a.key;
        o_sts.upd_less    = r_key_in < r_rd_a.key;
        o_sts.at_root     = r_pos == '0;
        o_sts.up_swap     = r_rd_a.key > r_mv.key;
        o_sts.no_child    = !l_ok;
        o_sts.dn_swap     = l_less || r_less;
        o_sts.clr_last    = r_clr == SLOT_W'(NUM_IDS - 1);
    end

    assign o_outcome     = r_o_outcome;
    assign o_out_id      = r_o_id;
    assign o_out_key     = r_o_key;
    assign o_entry_count = r_o_count;

    `IMH_NEVER(a_size_bound, i_clk, i_rst_n, r_size > CNT_W'(NUM_IDS), "heap size overflow")
    `IMH_ASSERT(a_final_in_heap, i_clk, i_rst_n, (i_cmd.op == DP_FINAL) |-> (CNT_W'(r_pos) < r_size), "final slot outside heap")
    `IMH_ASSERT(a_insert_grows, i_clk, i_rst_n, (i_cmd.op == DP_INSERT) |=> (r_size == $past(r_size) + CNT_W'(1)), "insert did not grow heap")

endmodule

### design/imh_ctrl.sv
// ----------------------------------------------------------------------------
// imh_ctrl
// Heap sequencer: clearing pass, decode, sift up/down steps, result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imh_ctrl
    import imh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LOOK,
        S_TAKE,
        S_TAKE2,
        S_UPD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_FINAL,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd.op      = DP_NONE;
        o_cmd.ld_outc = 1'b0;
        o_cmd.outc    = OUT_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = DP_CLR;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op      = DP_CAPTURE;
                    o_cmd.ld_outc = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.op = DP_FETCH;
                n_state  = S_LOOK;
            end
            S_LOOK: begin
                n_state = S_DONE;
                if (i_sts.mode == MODE_UPDATE && i_sts.id_valid) begin
                    if (i_sts.pres && !i_sts.elig) begin
                        o_cmd.op      = DP_SLOTRD;
                        o_cmd.ld_outc = 1'b1;
                        o_cmd.outc    = OUT_REMOVE;
                        n_state       = S_TAKE;
                    end else if (i_sts.pres) begin
                        o_cmd.op = DP_SLOTRD;
                        n_state  = S_UPD;
                    end else if (i_sts.elig && !i_sts.size_full) begin
                        o_cmd.op      = DP_INSERT;
                        o_cmd.ld_outc = 1'b1;
                        o_cmd.outc    = OUT_INSERT;
                        n_state       = S_UP_RD;
                    end
                end else if (i_sts.mode == MODE_POP) begin
                    o_cmd.ld_outc = 1'b1;
                    if (i_sts.size_zero) begin
                        o_cmd.outc = OUT_EMPTY;
                    end else begin
                        o_cmd.op   = DP_POP;
                        o_cmd.outc = OUT_POPPED;
                        if (!i_sts.size_one) begin
                            n_state = S_DN_RD;
                        end
                    end
                end else if (i_sts.mode == MODE_REMOVE && i_sts.id_valid
                             && !i_sts.size_zero && i_sts.pres) begin
                    o_cmd.op      = DP_SLOTRD;
                    o_cmd.ld_outc = 1'b1;
                    o_cmd.outc    = OUT_REMOVE;
                    n_state       = S_TAKE;
                end
            end
            S_TAKE: begin
                if (!i_sts.pos_ok) begin
                    o_cmd.op = DP_CLRPRES;
                    n_state  = S_DONE;
                end else if (i_sts.pos_is_last) begin
                    o_cmd.op = DP_TAKE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = DP_TAKE;
                    n_state  = S_TAKE2;
                end
            end
            S_TAKE2: begin
                if (i_sts.key_same) begin
                    n_state = S_FINAL;
                end else if (i_sts.key_less) begin
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_UPD: begin
                if (!i_sts.pos_ok || i_sts.upd_same) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op      = DP_UPDATE;
                    o_cmd.ld_outc = 1'b1;
                    o_cmd.outc    = OUT_KEYCHG;
                    n_state       = i_sts.upd_less ? S_UP_RD : S_DN_RD;
                end
            end
            S_UP_RD: begin
                if (i_sts.at_root) begin
                    n_state = S_FINAL;
                end else begin
                    o_cmd.op = DP_UP_RD;
                    n_state  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_sts.up_swap) begin
                    o_cmd.op = DP_UP_MOVE;
                    n_state  = S_UP_RD;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_DN_RD: begin
                if (i_sts.no_child) begin
                    n_state = S_FINAL;
                end else begin
                    o_cmd.op = DP_DN_RD;
                    n_state  = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_sts.dn_swap) begin
                    o_cmd.op = DP_DN_MOVE;
                    n_state  = S_DN_RD;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                o_cmd.op = DP_FINAL;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = DP_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `IMH_ASSERT(a_one_at_a_time, i_clk, i_rst_n, accept |=> !o_in_ready, "second item taken while busy")

endmodule

### design/indexed_min_heap.sv
// ----------------------------------------------------------------------------
// indexed_min_heap
// Addressable binary min-heap of item ids with an id-to-slot position map.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): mode, item id, key, eligible flag.
// Output channel (o_out_valid / i_out_ready): outcome, id, key, entry count.
// Exactly one result per input transfer, in order.
// One item is processed at a time. Each sift level is a slot memory read
// followed by a compare/write-back.
// The finished result sits in an output register; the next input transfer is
// accepted while it waits. If the receiver stalls, the following result waits
// in the sequencer until the output register frees up.
// After reset the presence map is cleared one entry per cycle, all NUM_IDS
// entries, with o_in_ready low; the heap starts empty.
// ----------------------------------------------------------------------------
module indexed_min_heap
    import imh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [ID_W-1:0]   i_item_id,
    input  logic [KEY_W-1:0]  i_new_key,
    input  logic              i_eligible,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [OUT_W-1:0]  o_outcome,
    output logic [ID_W-1:0]   o_out_id,
    output logic [KEY_W-1:0]  o_out_key,
    output logic [CNT_W-1:0]  o_entry_count
);

    t_cmd cmd;
    t_sts sts;

    imh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    imh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (i_mode),
        .i_item_id     (i_item_id),
        .i_new_key     (i_new_key),
        .i_eligible    (i_eligible),
        .o_sts         (sts),
        .o_outcome     (o_outcome),
        .o_out_id      (o_out_id),
        .o_out_key     (o_out_key),
        .o_entry_count (o_entry_count)
    );

endmodule
